// ===== src/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared constants and types for the ranging frame parser: framing codes,
// result status codes and the records passed between the parser stages.
// ----------------------------------------------------------------------------
package rfp_pkg;

   localparam int NumAnchorsDefault = 3;
   localparam int ByteWidth         = 8;
   localparam int IdWidth           = 16;
   localparam int DistWidth         = 32;
   localparam int PayloadLen        = 6;
   localparam int CountWidth        = 3;
   localparam int CsrIndexWidth     = 2;
   localparam int SlotWidth         = 2;
   localparam int StatusWidth       = 2;

   localparam logic [ByteWidth-1:0] SyncByte = 8'hFE;

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CHECK = 2'd2
   } phase_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_BAD_SUM   = 2'd1,
      ST_NO_ANCHOR = 2'd2
   } status_type;

   // completed frame, seen in the cycle its checksum byte is consumed
   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] sum;
      logic [ByteWidth-1:0] check;
      logic [IdWidth-1:0]   id;
      logic [DistWidth-1:0] distance;
   } frame_type;

   typedef struct packed {
      status_type           status;
      logic [SlotWidth-1:0] slot;
      logic [IdWidth-1:0]   id;
      logic [DistWidth-1:0] distance;
   } result_type;

endpackage

// ===== src/ranging_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ranging_frame_parser
// Finds sync-framed ranging packets in a received byte stream and reports
// one classified result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received byte per item (valid/ready).
//   rsp_*  : one result per frame, issued when the checksum byte is consumed:
//            status (accepted, bad checksum, unknown id), matching slot,
//            anchor id and raw distance word.
//   csr_*  : write-only anchor id registers, slot i at index i; write only
//            while no frame is in flight.
//   Path: an accepted checksum byte reaches rsp_* through two stages, the
//   input register and then the result register.
//   Throughput: one byte per cycle while no checksum byte is held; the input
//   register and result register let a new byte enter while a result waits.
//   Stall: while a result waits, non-checksum bytes keep flowing; a checksum
//   byte is held in the input register until the result register frees.
//   Reset: sync search, empty registers, anchor ids cleared to zero.
// ----------------------------------------------------------------------------
module ranging_frame_parser #(
   parameter int NUM_ANCHORS = rfp_pkg::NumAnchorsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rfp_pkg::ByteWidth-1:0]     req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rfp_pkg::StatusWidth-1:0]   rsp_frame_status,
   output logic [rfp_pkg::SlotWidth-1:0]     rsp_anchor_slot,
   output logic [rfp_pkg::IdWidth-1:0]       rsp_frame_anchor_id,
   output logic [rfp_pkg::DistWidth-1:0]     rsp_distance_bits,
   input  logic                              csr_we,
   input  logic [rfp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rfp_pkg::IdWidth-1:0]       csr_wdata
);
   import rfp_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff;
   logic                 consume;
   logic                 out_free;
   frame_type            frame;
   result_type           result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || consume;

   rfp_framer u_framer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .out_free (out_free),
      .consume  (consume),
      .frame    (frame)
   );

   rfp_classify #(
      .NUM_ANCHORS (NUM_ANCHORS)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .frame_i   (frame),
      .result_o  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (frame.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_status    = rsp_data_ff.status;
   assign rsp_anchor_slot     = rsp_data_ff.slot;
   assign rsp_frame_anchor_id = rsp_data_ff.id;
   assign rsp_distance_bits   = rsp_data_ff.distance;

endmodule

// ===== src/rfp_framer.sv =====
// ----------------------------------------------------------------------------
// rfp_framer
// Sync search, payload collection and running checksum. One byte per cycle;
// a frame shows as its checksum byte is taken, once the result reg is free.
// ----------------------------------------------------------------------------
module rfp_framer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [rfp_pkg::ByteWidth-1:0]  in_byte,
   input  logic                           out_free,
   output logic                           consume,
   output rfp_pkg::frame_type             frame
);
   import rfp_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [ByteWidth-1:0]  sum_ff, sum_in;
   logic [ByteWidth-1:0]  store_ff [PayloadLen];
   logic                  is_check;
   logic                  store_we;
   logic                  restart;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (consume) begin
         case (phase_ff)
            PH_DATA: begin
               if (count_ff + CountWidth'(1) == CountWidth'(PayloadLen)) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = PH_WAIT;
            end
            default: begin
               phase_in = (in_byte == SyncByte) ? PH_DATA : PH_WAIT;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      is_check = 1'b0;
      store_we = 1'b0;
      restart  = 1'b0;
      case (phase_ff)
         PH_DATA: begin
            store_we = 1'b1;
         end
         PH_CHECK: begin
            is_check = 1'b1;
         end
         default: begin
            restart = (in_byte == SyncByte);
         end
      endcase
   end

   // a checksum byte waits until the result register can take it
   assign consume = in_valid && (!is_check || out_free);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (consume && restart) begin
         count_in = '0;
         sum_in   = '0;
      end else if (consume && store_we) begin
         count_in = count_ff + CountWidth'(1);
         sum_in   = sum_ff + in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && store_we) begin
         store_ff[count_ff] <= in_byte;
      end
   end

   assign frame.valid    = consume && is_check;
   assign frame.sum      = sum_ff;
   assign frame.check    = in_byte;
   assign frame.id       = {store_ff[1], store_ff[0]};
   assign frame.distance = {store_ff[5], store_ff[4], store_ff[3], store_ff[2]};

`ifndef NO_ASSERTIONS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> count_ff < CountWidth'(PayloadLen))
      else $error("payload count out of range while collecting");

   a_check_after_full: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CHECK |-> count_ff == CountWidth'(PayloadLen))
      else $error("checksum phase entered before payload complete");

   a_wait_after_frame: assert property (@(posedge clock) disable iff (reset)
      frame.valid |=> phase_ff == PH_WAIT)
      else $error("parser did not return to sync search after a frame");
`endif

endmodule

// ===== src/rfp_classify.sv =====
// ----------------------------------------------------------------------------
// rfp_classify
// Anchor id registers and frame classification: checksum test, then a
// parallel id compare where the lowest matching slot wins.
// ----------------------------------------------------------------------------
module rfp_classify #(
   parameter int NUM_ANCHORS = rfp_pkg::NumAnchorsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rfp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rfp_pkg::IdWidth-1:0]       csr_wdata,
   input  rfp_pkg::frame_type                frame_i,
   output rfp_pkg::result_type               result_o
);
   import rfp_pkg::*;

   logic [IdWidth-1:0] ids_ff [NUM_ANCHORS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ANCHORS; i++) begin
            ids_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_ANCHORS; i++) begin
            if (csr_we && csr_index == CsrIndexWidth'(i)) begin
               ids_ff[i] <= csr_wdata;
            end
         end
      end
   end

   always_comb begin
      result_o.status   = ST_NO_ANCHOR;
      result_o.slot     = '0;
      result_o.id       = frame_i.id;
      result_o.distance = frame_i.distance;
      if (frame_i.sum != frame_i.check) begin
         result_o.status = ST_BAD_SUM;
      end else begin
         // walk downward so the lowest matching slot is the one kept
         for (int i = NUM_ANCHORS - 1; i >= 0; i--) begin
            if (ids_ff[i] == frame_i.id) begin
               result_o.status = ST_ACCEPTED;
               result_o.slot   = SlotWidth'(i);
            end
         end
      end
   end

endmodule
